// ----- hw/rtl/assert_macros.svh -----
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising edge, off while reset is asserted.
`define OWBM_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Check a property on every rising edge, reset included.
`define OWBM_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) (prop)) else $error(msg);

`endif

// ----- hw/rtl/owbm_pkg.sv -----
package owbm_pkg;

  localparam int CountWidth = 10;
  localparam int RegWidth   = 10;
  localparam int NumRegs    = 8;
  localparam int IdxWidth   = 3;
  localparam int PhaseWidth = 4;

  localparam logic [1:0] OpTick  = 2'd0;
  localparam logic [1:0] OpReset = 2'd1;
  localparam logic [1:0] OpWrite = 2'd2;
  localparam logic [1:0] OpRead  = 2'd3;

  localparam logic [IdxWidth-1:0] RegResetLow   = 3'd0;
  localparam logic [IdxWidth-1:0] RegPresWait   = 3'd1;
  localparam logic [IdxWidth-1:0] RegResetTail  = 3'd2;
  localparam logic [IdxWidth-1:0] RegSlotShort  = 3'd3;
  localparam logic [IdxWidth-1:0] RegSlotLong   = 3'd4;
  localparam logic [IdxWidth-1:0] RegReadWait   = 3'd5;
  localparam logic [IdxWidth-1:0] RegReadTail   = 3'd6;
  localparam logic [IdxWidth-1:0] RegBitGap     = 3'd7;

  localparam logic [RegWidth-1:0] RstResetLow  = 10'd480;
  localparam logic [RegWidth-1:0] RstPresWait  = 10'd65;
  localparam logic [RegWidth-1:0] RstResetTail = 10'd420;
  localparam logic [RegWidth-1:0] RstSlotShort = 10'd3;
  localparam logic [RegWidth-1:0] RstSlotLong  = 10'd65;
  localparam logic [RegWidth-1:0] RstReadWait  = 10'd15;
  localparam logic [RegWidth-1:0] RstReadTail  = 10'd50;
  localparam logic [RegWidth-1:0] RstBitGap    = 10'd5;

  typedef struct packed {
    logic [RegWidth-1:0] reset_low;
    logic [RegWidth-1:0] presence_wait;
    logic [RegWidth-1:0] reset_tail;
    logic [RegWidth-1:0] slot_short;
    logic [RegWidth-1:0] slot_long;
    logic [RegWidth-1:0] read_sample_wait;
    logic [RegWidth-1:0] read_tail;
    logic [RegWidth-1:0] bit_gap;
  } cfg_t;

  typedef struct packed {
    logic       line_low;
    logic       busy;
    logic       done;
    logic       no_presence;
    logic [7:0] read_data;
    logic       command_ignored;
  } result_t;

endpackage

// ----- hw/rtl/owbm_cfg_regs.sv -----
module owbm_cfg_regs
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  logic [IdxWidth-1:0] wr_index_i,
  input  logic [RegWidth-1:0] wr_data_i,
  output cfg_t                cfg_o
);

  cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en_i) begin
      unique case (wr_index_i)
        RegResetLow:  cfg_d.reset_low        = wr_data_i;
        RegPresWait:  cfg_d.presence_wait    = wr_data_i;
        RegResetTail: cfg_d.reset_tail       = wr_data_i;
        RegSlotShort: cfg_d.slot_short       = wr_data_i;
        RegSlotLong:  cfg_d.slot_long        = wr_data_i;
        RegReadWait:  cfg_d.read_sample_wait = wr_data_i;
        RegReadTail:  cfg_d.read_tail        = wr_data_i;
        RegBitGap:    cfg_d.bit_gap          = wr_data_i;
        default:      cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.reset_low        <= RstResetLow;
      cfg_q.presence_wait    <= RstPresWait;
      cfg_q.reset_tail       <= RstResetTail;
      cfg_q.slot_short       <= RstSlotShort;
      cfg_q.slot_long        <= RstSlotLong;
      cfg_q.read_sample_wait <= RstReadWait;
      cfg_q.read_tail        <= RstReadTail;
      cfg_q.bit_gap          <= RstBitGap;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ----- hw/rtl/owbm_seq.sv -----
module owbm_seq
  import owbm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       step_i,
  input  logic [1:0] opcode_i,
  input  logic [7:0] write_data_i,
  input  logic       line_sample_i,
  input  cfg_t       cfg_i,
  output result_t    result_o
);

  localparam logic [PhaseWidth-1:0] PhIdle    = 4'd0;
  localparam logic [PhaseWidth-1:0] PhRstLow  = 4'd1;
  localparam logic [PhaseWidth-1:0] PhRstWait = 4'd2;
  localparam logic [PhaseWidth-1:0] PhRstTail = 4'd3;
  localparam logic [PhaseWidth-1:0] PhWrLow   = 4'd4;
  localparam logic [PhaseWidth-1:0] PhWrHigh  = 4'd5;
  localparam logic [PhaseWidth-1:0] PhWrGap   = 4'd6;
  localparam logic [PhaseWidth-1:0] PhRdLow   = 4'd7;
  localparam logic [PhaseWidth-1:0] PhRdWait  = 4'd8;
  localparam logic [PhaseWidth-1:0] PhRdTail  = 4'd9;

  localparam int CmpWidth = ((CountWidth > RegWidth) ? CountWidth : RegWidth) + 1;
  localparam logic [CmpWidth-1:0]   LenTop   = CmpWidth'(2 ** CountWidth);
  localparam logic [CountWidth-1:0] CountMax = {CountWidth{1'b1}};
  localparam logic [2:0]            BitLast  = 3'd7;

  logic [PhaseWidth-1:0] phase_q, phase_d;
  logic [CountWidth-1:0] tick_q, tick_d;
  logic [2:0]            bit_q, bit_d;
  logic [7:0]            shift_q, shift_d;
  logic                  pres_q, pres_d;
  logic [7:0]            rbyte_q, rbyte_d;

  logic [RegWidth-1:0] len;
  logic [CmpWidth-1:0] len_ext, len_eff, tick_inc;
  logic                cur_bit, phase_end, done, ignored, bit_end;

  assign cur_bit = shift_q[bit_q];

  always_comb begin
    unique case (phase_q)
      PhRstLow:  len = cfg_i.reset_low;
      PhRstWait: len = cfg_i.presence_wait;
      PhRstTail: len = cfg_i.reset_tail;
      PhWrLow:   len = cur_bit ? cfg_i.slot_short : cfg_i.slot_long;
      PhWrHigh:  len = cur_bit ? cfg_i.slot_long : cfg_i.slot_short;
      PhWrGap:   len = cfg_i.bit_gap;
      PhRdLow:   len = cfg_i.slot_short;
      PhRdWait:  len = cfg_i.read_sample_wait;
      PhRdTail:  len = cfg_i.read_tail;
      default:   len = RegWidth'(1);
    endcase
  end

  assign len_ext   = CmpWidth'(len);
  assign len_eff   = (len_ext == '0) ? CmpWidth'(1) : ((len_ext > LenTop) ? LenTop : len_ext);
  assign tick_inc  = CmpWidth'(tick_q) + CmpWidth'(1);
  assign phase_end = (tick_inc >= len_eff);

  always_comb begin
    phase_d = phase_q;
    tick_d  = tick_q;
    bit_d   = bit_q;
    shift_d = shift_q;
    pres_d  = pres_q;
    rbyte_d = rbyte_q;
    done    = 1'b0;
    ignored = 1'b0;
    bit_end = 1'b0;
    if (phase_q == PhIdle) begin
      unique case (opcode_i)
        OpTick: ;
        OpReset: begin
          phase_d = PhRstLow;
          tick_d  = '0;
        end
        OpWrite: begin
          phase_d = PhWrLow;
          tick_d  = '0;
          shift_d = write_data_i;
          bit_d   = '0;
        end
        OpRead: begin
          phase_d = PhRdLow;
          tick_d  = '0;
          shift_d = '0;
          bit_d   = '0;
        end
        default: ;
      endcase
    end else begin
      ignored = (opcode_i != OpTick);
      if (phase_end) begin
        tick_d = '0;
        unique case (phase_q)
          PhRstLow:  phase_d = PhRstWait;
          PhRstWait: begin
            pres_d  = line_sample_i;
            phase_d = PhRstTail;
          end
          PhRstTail: begin
            phase_d = PhIdle;
            done    = 1'b1;
          end
          PhWrLow:   phase_d = PhWrHigh;
          PhWrHigh: begin
            if (cfg_i.bit_gap != '0) phase_d = PhWrGap;
            else bit_end = 1'b1;
          end
          PhWrGap:   bit_end = 1'b1;
          PhRdLow:   phase_d = PhRdWait;
          PhRdWait: begin
            shift_d[bit_q] = shift_q[bit_q] | line_sample_i;
            phase_d        = PhRdTail;
          end
          PhRdTail: begin
            if (bit_q == BitLast) begin
              rbyte_d = shift_q;
              phase_d = PhIdle;
              done    = 1'b1;
            end else begin
              bit_d   = bit_q + 3'd1;
              phase_d = PhRdLow;
            end
          end
          default:   phase_d = PhIdle;
        endcase
        if (bit_end) begin
          if (bit_q == BitLast) begin
            phase_d = PhIdle;
            done    = 1'b1;
          end else begin
            bit_d   = bit_q + 3'd1;
            phase_d = PhWrLow;
          end
        end
      end else if (tick_q < CountMax) begin
        tick_d = tick_q + CountWidth'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
      tick_q  <= '0;
      bit_q   <= '0;
      shift_q <= '0;
      pres_q  <= 1'b0;
      rbyte_q <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      tick_q  <= tick_d;
      bit_q   <= bit_d;
      shift_q <= shift_d;
      pres_q  <= pres_d;
      rbyte_q <= rbyte_d;
    end
  end

  always_comb begin
    result_o.line_low        = (phase_d == PhRstLow) || (phase_d == PhWrLow) ||
                               (phase_d == PhRdLow);
    result_o.busy            = (phase_d != PhIdle);
    result_o.done            = done;
    result_o.no_presence     = pres_d;
    result_o.read_data       = rbyte_d;
    result_o.command_ignored = ignored;
  end

endmodule

// ----- hw/rtl/owbm_out_skid.sv -----
module owbm_out_skid
  import owbm_pkg::*;
(
  input  logic    clk_i,
  input  logic    rst_ni,
  input  logic    push_i,
  input  result_t data_i,
  output logic    ready_o,
  output logic    valid_o,
  input  logic    ready_i,
  output result_t data_o
);

  result_t out_q, skid_q;
  logic    out_v_q, skid_v_q;
  logic    load_out;

  assign ready_o  = !skid_v_q;
  assign load_out = !out_v_q || ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (load_out) begin
      out_v_q  <= skid_v_q || push_i;
      skid_v_q <= 1'b0;
    end else if (push_i) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      out_q <= skid_v_q ? skid_q : data_i;
    end else if (push_i) begin
      skid_q <= data_i;
    end
  end

  assign valid_o = out_v_q;
  assign data_o  = out_q;

endmodule

// ----- hw/rtl/one_wire_bus_master.sv -----
// One-wire bus master sequencer, one transfer per timing tick.
// Input channel (in_valid_i/in_ready_o): each transfer is one tick and carries
// opcode_i (tick, reset, write byte, read byte), write_data_i and the sampled
// bus level line_sample_i. Commands given while busy are dropped and flagged.
// Output channel (out_valid_o/out_ready_i): one result transfer per input tick,
// in order: line drive, busy, done pulse, presence failure, last read byte and
// the ignored-command flag, all as the state after that tick.
// Config channel (cfg_valid_i/cfg_ready_o): always ready; cfg_index_i selects
// one of the eight timing registers, write it only while the block is idle.
// Results are registered in the output entry, or in the skid entry while the
// receiver stalls. Throughput: one tick per cycle while in_ready_o is high; the
// phase counter and slot sequencer update once per tick.
// A two-entry output buffer keeps accepting ticks into its skid entry when the
// receiver stalls; in_ready_o drops only while both entries are full.
// Reset: timing registers return to their defaults, the sequencer goes idle
// with cleared flags and read byte, and the output buffer empties.
module one_wire_bus_master
  import owbm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  logic [1:0]          opcode_i,
  input  logic [7:0]          write_data_i,
  input  logic                line_sample_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic                line_low_o,
  output logic                busy_res_o,
  output logic                done_res_o,
  output logic                no_presence_o,
  output logic [7:0]          read_data_o,
  output logic                command_ignored_o,
  input  logic                cfg_valid_i,
  output logic                cfg_ready_o,
  input  logic [IdxWidth-1:0] cfg_index_i,
  input  logic [RegWidth-1:0] cfg_data_i
);

  `include "assert_macros.svh"

  cfg_t    cfg;
  result_t seq_res, out_res;
  logic    in_xfer;

  assign cfg_ready_o = 1'b1;
  assign in_xfer     = in_valid_i && in_ready_o;

  owbm_cfg_regs u_cfg (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .wr_en_i    (cfg_valid_i && cfg_ready_o),
    .wr_index_i (cfg_index_i),
    .wr_data_i  (cfg_data_i),
    .cfg_o      (cfg)
  );

  owbm_seq u_seq (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .step_i        (in_xfer),
    .opcode_i      (opcode_i),
    .write_data_i  (write_data_i),
    .line_sample_i (line_sample_i),
    .cfg_i         (cfg),
    .result_o      (seq_res)
  );

  owbm_out_skid u_out (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (in_xfer),
    .data_i  (seq_res),
    .ready_o (in_ready_o),
    .valid_o (out_valid_o),
    .ready_i (out_ready_i),
    .data_o  (out_res)
  );

  assign line_low_o        = out_res.line_low;
  assign busy_res_o        = out_res.busy;
  assign done_res_o        = out_res.done;
  assign no_presence_o     = out_res.no_presence;
  assign read_data_o       = out_res.read_data;
  assign command_ignored_o = out_res.command_ignored;

  `OWBM_ASSERT(a_done_idle, out_valid_o && done_res_o |-> !busy_res_o, "done while busy")
  `OWBM_ASSERT(a_low_busy, out_valid_o && line_low_o |-> busy_res_o, "line driven while idle")
  `OWBM_ASSERT(a_stall_full, !in_ready_o |-> out_valid_o, "input stalled with empty output")
  `OWBM_ASSERT(a_stall_hold, out_valid_o && !out_ready_i |=> out_valid_o, "result lost in stall")

endmodule
